### sv/assert_macros.svh
// Assertion macros shared by the blur row filter RTL.
// Included by every file that checks its own logic; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SBR_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SBR_ASSERT(label, clk, rst_n, prop)
`define SBR_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### sv/sbr_pkg.sv
// Types and constants of the blur row filter.
// Used by sbr_cell, sbr_acc and separable_blur_row_filter; depends on nothing.
`timescale 1ns / 1ps
package sbr_pkg;

  localparam int PIX_W       = 8;
  localparam int NUM_CH      = 4;
  localparam int WGT_W       = 16;
  localparam int PROD_W      = 24;
  localparam int SUM_W       = 27;
  localparam int FRAC_W      = 14;
  localparam int NUM_WEIGHTS = 7;
  localparam int CENTRE_IDX  = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CH_ALPHA    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEEP_ALPHA = 3'd7;
  localparam logic signed [WGT_W-1:0] WEIGHT_ONE  = 16'sd16384;

  typedef logic [NUM_CH-1:0][PIX_W-1:0] pixel_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic shift;
    logic fill;
    logic capture;
  } cell_ctrl_t;

  typedef struct packed {
    logic part_en;
    logic out_en;
  } acc_ctrl_t;

endpackage

### sv/sbr_cell.sv
// One tap cell of the blur window: holds a pixel, passes it on, and
// registers the weighted products of its four channels. Depends on sbr_pkg.
`timescale 1ns / 1ps
module sbr_cell (
  input  logic                                clk_i,
  input  sbr_pkg::cell_ctrl_t                 ctrl_i,
  input  sbr_pkg::pixel_t                     head_px_i,
  input  sbr_pkg::pixel_t                     nbr_px_i,
  input  logic signed [sbr_pkg::WGT_W-1:0]    weight_i,
  output sbr_pkg::pixel_t                     px_o,
  output sbr_pkg::prod_t                      prod_o [sbr_pkg::NUM_CH]
);

  sbr_pkg::pixel_t px_q;
  sbr_pkg::prod_t  prod_q [sbr_pkg::NUM_CH];
  logic signed [sbr_pkg::WGT_W+sbr_pkg::PIX_W:0] full_d [sbr_pkg::NUM_CH];

  always_comb begin
    for (int ch = 0; ch < sbr_pkg::NUM_CH; ch++) begin
      full_d[ch] = weight_i * $signed({1'b0, px_q[ch]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      px_q <= ctrl_i.fill ? head_px_i : nbr_px_i;
    end
    if (ctrl_i.capture) begin
      for (int ch = 0; ch < sbr_pkg::NUM_CH; ch++) begin
        prod_q[ch] <= full_d[ch][sbr_pkg::PROD_W-1:0];
      end
    end
  end

  assign px_o   = px_q;
  assign prod_o = prod_q;

endmodule

### sv/sbr_acc.sv
// Sums the tap products in two register stages and saturates each channel;
// alpha may instead keep the centre pixel's alpha. Depends on sbr_pkg.
`timescale 1ns / 1ps
module sbr_acc #(
  parameter int NCELL = 7
) (
  input  logic                      clk_i,
  input  sbr_pkg::acc_ctrl_t        ctrl_i,
  input  sbr_pkg::prod_t            prod_i [NCELL][sbr_pkg::NUM_CH],
  input  logic [sbr_pkg::PIX_W-1:0] ctr_alpha_i,
  input  logic                      keep_alpha_i,
  output sbr_pkg::pixel_t           out_px_o
);

  localparam int NA = (NCELL + 1) / 2;

  sbr_pkg::sum_t sa_d [sbr_pkg::NUM_CH];
  sbr_pkg::sum_t sb_d [sbr_pkg::NUM_CH];
  sbr_pkg::sum_t sa_q [sbr_pkg::NUM_CH];
  sbr_pkg::sum_t sb_q [sbr_pkg::NUM_CH];
  sbr_pkg::sum_t tot_d [sbr_pkg::NUM_CH];
  logic [sbr_pkg::PIX_W-1:0] alpha_q;
  sbr_pkg::pixel_t out_q;

  function automatic logic [sbr_pkg::PIX_W-1:0] sat_byte(input sbr_pkg::sum_t s);
    if (s[sbr_pkg::SUM_W-1]) begin
      return '0;
    end else if (|s[sbr_pkg::SUM_W-2:sbr_pkg::FRAC_W+sbr_pkg::PIX_W]) begin
      return '1;
    end else begin
      return s[sbr_pkg::FRAC_W+sbr_pkg::PIX_W-1:sbr_pkg::FRAC_W];
    end
  endfunction

  always_comb begin
    for (int ch = 0; ch < sbr_pkg::NUM_CH; ch++) begin
      sa_d[ch] = '0;
      sb_d[ch] = '0;
      for (int k = 0; k < NCELL; k++) begin
        if (k < NA) begin
          sa_d[ch] = sa_d[ch] + sbr_pkg::SUM_W'(prod_i[k][ch]);
        end else begin
          sb_d[ch] = sb_d[ch] + sbr_pkg::SUM_W'(prod_i[k][ch]);
        end
      end
      tot_d[ch] = sa_q[ch] + sb_q[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.part_en) begin
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      alpha_q <= ctr_alpha_i;
    end
    if (ctrl_i.out_en) begin
      for (int ch = 0; ch < sbr_pkg::CH_ALPHA; ch++) begin
        out_q[ch] <= sat_byte(tot_d[ch]);
      end
      out_q[sbr_pkg::CH_ALPHA] <= keep_alpha_i ? alpha_q
                                               : sat_byte(tot_d[sbr_pkg::CH_ALPHA]);
    end
  end

  assign out_px_o = out_q;

endmodule

### sv/separable_blur_row_filter.sv
// Top level of the horizontal blur pass: window cells, row control and sums.
// Depends on sbr_pkg, sbr_cell, sbr_acc and assert_macros.svh.
//
//  Channel  | Handshake                      | Payload
//  ---------+--------------------------------+------------------------------------
//  input    | in_valid_i / in_stall_o        | red/green/blue/alpha_in_i, row_end_i
//  output   | out_valid_o / out_stall_i      | red/green/blue/alpha_out_o, row_last_o
//  config   | cfg_we_i                       | cfg_index_i, cfg_data_i
//
// One item is taken per cycle while in_stall_o is low; each result passes the
// products, partial sums and output registers. After a row_end item the cells
// shift TAPS/2 more times, replicating the last pixel, with the input stalled.
// Reset clears the row and pipeline state and sets identity weights.
// An output stall holds the result register and backs up stage by stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module separable_blur_row_filter #(
  parameter int TAPS = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sbr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sbr_pkg::WGT_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [sbr_pkg::PIX_W-1:0]           red_in_i,
  input  logic [sbr_pkg::PIX_W-1:0]           green_in_i,
  input  logic [sbr_pkg::PIX_W-1:0]           blue_in_i,
  input  logic [sbr_pkg::PIX_W-1:0]           alpha_in_i,
  input  logic                                row_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sbr_pkg::PIX_W-1:0]           red_out_o,
  output logic [sbr_pkg::PIX_W-1:0]           green_out_o,
  output logic [sbr_pkg::PIX_W-1:0]           blue_out_o,
  output logic [sbr_pkg::PIX_W-1:0]           alpha_out_o,
  output logic                                row_last_o
);

  localparam int HALF  = TAPS / 2;
  localparam int NCELL = 2 * HALF + 1;
  localparam int PW    = ($clog2(HALF + 1) > 0) ? $clog2(HALF + 1) : 1;
  localparam logic [PW-1:0] HALF_P = PW'(HALF);

  logic signed [sbr_pkg::WGT_W-1:0] weight_q [sbr_pkg::NUM_WEIGHTS];
  logic keep_alpha_q;

  logic [PW-1:0] pos_q, pos_d, pos_inc, tail_cnt_q, tail_cnt_d;
  logic win_vld_q, win_vld_d, win_last_q, win_last_d;
  logic prod_vld_q, part_vld_q, out_vld_q;
  logic prod_last_q, part_last_q, out_last_q;
  logic [sbr_pkg::PIX_W-1:0] ctr_alpha_q;

  logic out_rdy, part_rdy, prod_rdy, win_rdy;
  logic tail_act, in_acc, tail_shift, shift;

  sbr_pkg::cell_ctrl_t cell_ctrl;
  sbr_pkg::acc_ctrl_t  acc_ctrl;
  sbr_pkg::pixel_t     head_px;
  sbr_pkg::pixel_t     in_px;
  sbr_pkg::pixel_t     cell_px [NCELL];
  sbr_pkg::pixel_t     cell_nbr [NCELL];
  sbr_pkg::prod_t      cell_prod [NCELL][sbr_pkg::NUM_CH];
  sbr_pkg::pixel_t     out_px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sbr_pkg::NUM_WEIGHTS; i++) begin
        weight_q[i] <= '0;
      end
      weight_q[sbr_pkg::CENTRE_IDX] <= sbr_pkg::WEIGHT_ONE;
      keep_alpha_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sbr_pkg::REG_KEEP_ALPHA: keep_alpha_q <= cfg_data_i[0];
        default:                 weight_q[cfg_index_i] <= cfg_data_i;
      endcase
    end
  end

  assign out_rdy    = !out_vld_q || !out_stall_i;
  assign part_rdy   = !part_vld_q || out_rdy;
  assign prod_rdy   = !prod_vld_q || part_rdy;
  assign win_rdy    = !win_vld_q || prod_rdy;
  assign tail_act   = tail_cnt_q != '0;
  assign in_stall_o = tail_act || !win_rdy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tail_shift = tail_act && win_rdy;
  assign shift      = in_acc || tail_shift;

  assign in_px   = {alpha_in_i, blue_in_i, green_in_i, red_in_i};
  assign head_px = tail_act ? cell_px[0] : in_px;
  assign pos_inc = (pos_q == HALF_P) ? pos_q : pos_q + PW'(1);

  assign cell_ctrl.shift   = shift;
  assign cell_ctrl.fill    = in_acc && (pos_q == '0);
  assign cell_ctrl.capture = prod_rdy && win_vld_q;
  assign acc_ctrl.part_en  = part_rdy && prod_vld_q;
  assign acc_ctrl.out_en   = out_rdy && part_vld_q;

  always_comb begin
    pos_d      = pos_q;
    tail_cnt_d = tail_cnt_q;
    win_vld_d  = win_vld_q;
    win_last_d = win_last_q;
    if (win_rdy) begin
      win_vld_d  = shift && (pos_q >= HALF_P);
      win_last_d = 1'b0;
    end
    if (in_acc) begin
      pos_d = pos_inc;
      if (row_end_i) begin
        tail_cnt_d = HALF_P;
        if (HALF == 0) begin
          pos_d      = '0;
          win_last_d = 1'b1;
        end
      end
    end else if (tail_shift) begin
      tail_cnt_d = tail_cnt_q - PW'(1);
      pos_d      = pos_inc;
      if (tail_cnt_q == PW'(1)) begin
        pos_d      = '0;
        win_last_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      tail_cnt_q <= '0;
      win_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      part_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      tail_cnt_q <= tail_cnt_d;
      win_vld_q  <= win_vld_d;
      if (prod_rdy) begin
        prod_vld_q <= win_vld_q;
      end
      if (part_rdy) begin
        part_vld_q <= prod_vld_q;
      end
      if (out_rdy) begin
        out_vld_q <= part_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_last_q <= win_last_d;
    if (cell_ctrl.capture) begin
      prod_last_q <= win_last_q;
      ctr_alpha_q <= cell_px[HALF][sbr_pkg::CH_ALPHA];
    end
    if (acc_ctrl.part_en) begin
      part_last_q <= prod_last_q;
    end
    if (acc_ctrl.out_en) begin
      out_last_q <= part_last_q;
    end
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    localparam int WIDX = sbr_pkg::CENTRE_IDX + HALF - k;
    if (k == 0) begin : g_head
      assign cell_nbr[k] = head_px;
    end else begin : g_body
      assign cell_nbr[k] = cell_px[k-1];
    end
    sbr_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .head_px_i (head_px),
      .nbr_px_i  (cell_nbr[k]),
      .weight_i  (weight_q[WIDX]),
      .px_o      (cell_px[k]),
      .prod_o    (cell_prod[k])
    );
  end

  sbr_acc #(
    .NCELL (NCELL)
  ) u_acc (
    .clk_i        (clk_i),
    .ctrl_i       (acc_ctrl),
    .prod_i       (cell_prod),
    .ctr_alpha_i  (ctr_alpha_q),
    .keep_alpha_i (keep_alpha_q),
    .out_px_o     (out_px)
  );

  assign out_valid_o = out_vld_q;
  assign red_out_o   = out_px[0];
  assign green_out_o = out_px[1];
  assign blue_out_o  = out_px[2];
  assign alpha_out_o = out_px[sbr_pkg::CH_ALPHA];
  assign row_last_o  = out_last_q;

  `SBR_ASSERT_NEVER(a_pos_bound, clk_i, rst_ni, pos_q > HALF_P)
  `SBR_ASSERT_NEVER(a_no_accept_in_tail, clk_i, rst_ni, tail_act && in_acc)
  `SBR_ASSERT(a_win_hold, clk_i, rst_ni, (win_vld_q && !prod_rdy) |=> win_vld_q)
  `SBR_ASSERT(a_row_restart, clk_i, rst_ni, $fell(tail_act) |-> (pos_q == '0))

endmodule
